// ----- hdl/plwi_pkg.sv -----
// Shared types and constants for the piecewise linear table interpolator.
package plwi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIV_CNT_W  = $clog2(DATA_WIDTH + 1);

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_QUERY,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] key;
        logic [DATA_WIDTH-1:0] level;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_QSCAN,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_DONE
    } t_state;

endpackage

// ----- hdl/plwi_front.sv -----
// Front end: accepts items, classifies the request and queues commands.
module plwi_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_req_type,
    input  logic [plwi_pkg::DATA_WIDTH-1:0] i_point_position,
    input  logic [plwi_pkg::DATA_WIDTH-1:0] i_point_level,
    input  logic [plwi_pkg::DATA_WIDTH-1:0] i_query_position,
    output logic                            o_cmd_valid,
    output plwi_pkg::t_cmd                  o_cmd,
    input  logic                            i_cmd_take
);
    import plwi_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_wr, w_rd;

    always_comb begin
        unique case (i_req_type)
            REQ_CLEAR:  w_cmd.op = OP_CLEAR;
            REQ_INSERT: w_cmd.op = OP_INSERT;
            REQ_QUERY:  w_cmd.op = OP_QUERY;
            default:    w_cmd.op = OP_NOP;
        endcase
        w_cmd.key   = (i_req_type == REQ_QUERY) ? i_query_position : i_point_position;
        w_cmd.level = i_point_level;
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- hdl/plwi_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients below 2^DATA_WIDTH.
module plwi_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2*plwi_pkg::DATA_WIDTH-1:0] i_dividend,
    input  logic [plwi_pkg::DATA_WIDTH-1:0]   i_divisor,
    output logic                              o_done,
    output logic [plwi_pkg::DATA_WIDTH-1:0]   o_quot
);
    import plwi_pkg::*;

    logic [DATA_WIDTH:0]    r_rem, n_rem;
    logic [DATA_WIDTH-1:0]  r_lo, r_d, r_q;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_busy, r_done;
    logic [DATA_WIDTH:0]    w_trial;
    logic                   w_ge;

    assign w_trial = {r_rem[DATA_WIDTH-1:0], r_lo[DATA_WIDTH-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign n_rem   = w_ge ? (w_trial - {1'b0, r_d}) : w_trial;
    assign o_done  = r_done;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[2*DATA_WIDTH-1:DATA_WIDTH]};
            r_lo  <= i_dividend[DATA_WIDTH-1:0];
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[DATA_WIDTH-2:0], 1'b0};
            r_q   <= {r_q[DATA_WIDTH-2:0], w_ge};
        end
    end

endmodule

// ----- hdl/plwi_back.sv -----
// Back end: breakpoint table, search sequencer, interpolation and result register.
module plwi_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  plwi_pkg::t_cmd                  i_cmd,
    output logic                            o_cmd_take,
    output logic                            empty,
    input  logic                            pop,
    output logic [plwi_pkg::DATA_WIDTH-1:0] o_interp_level,
    output logic [1:0]                      o_status,
    output logic [plwi_pkg::CNT_W-1:0]      o_entry_count
);
    import plwi_pkg::*;

    localparam logic signed [DATA_WIDTH+1:0] SAT_MAX = $signed({3'b000, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [DATA_WIDTH+1:0] SAT_MIN = -SAT_MAX - 1;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count, r_idx, n_idx;
    logic [DATA_WIDTH-1:0]   r_key, n_key, r_lvl_in, n_lvl_in;
    logic [DATA_WIDTH-1:0]   r_prev_pos, n_prev_pos, r_prev_lvl, n_prev_lvl;
    logic [DATA_WIDTH-1:0]   r_a, n_a, r_b, n_b, r_d, n_d, r_v0, n_v0;
    logic                    r_neg, n_neg;
    logic [2*DATA_WIDTH-1:0] r_prod, n_prod;
    logic [DATA_WIDTH-1:0]   r_st_level, n_st_level;
    logic [1:0]              r_st_status, n_st_status;
    logic                    r_res_valid, n_res_valid;
    logic [DATA_WIDTH-1:0]   r_res_level, n_res_level;
    logic [1:0]              r_res_status, n_res_status;
    logic [CNT_W-1:0]        r_res_count, n_res_count;
    logic [DATA_WIDTH-1:0]   r_pos [MAX_POINTS];
    logic [DATA_WIDTH-1:0]   r_lvl [MAX_POINTS];

    logic [DATA_WIDTH-1:0]   w_rd_pos, w_rd_lvl, w_quot;
    logic                    w_ins, w_rep, w_div_start, w_div_done;
    logic signed [DATA_WIDTH+1:0] w_sum;

    assign w_rd_pos       = r_pos[r_idx[IDX_W-1:0]];
    assign w_rd_lvl       = r_lvl[r_idx[IDX_W-1:0]];
    assign empty          = !r_res_valid;
    assign o_interp_level = r_res_level;
    assign o_status       = r_res_status;
    assign o_entry_count  = r_res_count;

    plwi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        if (r_neg) begin
            w_sum = $signed({{2{r_v0[DATA_WIDTH-1]}}, r_v0}) - $signed({2'b00, w_quot});
        end else begin
            w_sum = $signed({{2{r_v0[DATA_WIDTH-1]}}, r_v0}) + $signed({2'b00, w_quot});
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_lvl_in     = r_lvl_in;
        n_prev_pos   = r_prev_pos;
        n_prev_lvl   = r_prev_lvl;
        n_a          = r_a;
        n_b          = r_b;
        n_d          = r_d;
        n_v0         = r_v0;
        n_neg        = r_neg;
        n_prod       = r_prod;
        n_st_level   = r_st_level;
        n_st_status  = r_st_status;
        n_res_valid  = r_res_valid && !pop;
        n_res_level  = r_res_level;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        o_cmd_take   = 1'b0;
        w_ins        = 1'b0;
        w_rep        = 1'b0;
        w_div_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take  = 1'b1;
                    n_key       = i_cmd.key;
                    n_lvl_in    = i_cmd.level;
                    n_idx       = '0;
                    n_st_level  = '0;
                    n_st_status = ST_OK;
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        OP_INSERT: n_state = S_INS;
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_st_status = ST_EMPTY;
                                n_state     = S_DONE;
                            end else begin
                                n_state = S_QSCAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                if (r_idx == r_count || $signed(w_rd_pos) >= $signed(r_key)) begin
                    if (r_idx != r_count && w_rd_pos == r_key) begin
                        w_rep = 1'b1;
                    end else if (r_count == CNT_W'(MAX_POINTS)) begin
                        n_st_status = ST_FULL;
                    end else begin
                        w_ins   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_QSCAN: begin
                if (r_idx == r_count) begin
                    n_st_level = r_prev_lvl;
                    n_state    = S_DONE;
                end else if ($signed(w_rd_pos) > $signed(r_key)) begin
                    if (r_idx == '0) begin
                        n_st_level = w_rd_lvl;
                        n_state    = S_DONE;
                    end else begin
                        n_a   = r_key - r_prev_pos;
                        n_d   = w_rd_pos - r_prev_pos;
                        n_neg = $signed(w_rd_lvl) < $signed(r_prev_lvl);
                        n_b   = n_neg ? (r_prev_lvl - w_rd_lvl) : (w_rd_lvl - r_prev_lvl);
                        n_v0  = r_prev_lvl;
                        n_state = S_MUL;
                    end
                end else begin
                    n_prev_pos = w_rd_pos;
                    n_prev_lvl = w_rd_lvl;
                    n_idx      = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                n_prod  = r_a * r_b;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                w_div_start = 1'b1;
                n_state     = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    priority if (w_sum > SAT_MAX) begin
                        n_st_level = SAT_MAX[DATA_WIDTH-1:0];
                    end else if (w_sum < SAT_MIN) begin
                        n_st_level = SAT_MIN[DATA_WIDTH-1:0];
                    end else begin
                        n_st_level = w_sum[DATA_WIDTH-1:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_res_valid || pop) begin
                    n_res_valid  = 1'b1;
                    n_res_level  = r_st_level;
                    n_res_status = r_st_status;
                    n_res_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_key        <= n_key;
        r_lvl_in     <= n_lvl_in;
        r_prev_pos   <= n_prev_pos;
        r_prev_lvl   <= n_prev_lvl;
        r_a          <= n_a;
        r_b          <= n_b;
        r_d          <= n_d;
        r_v0         <= n_v0;
        r_neg        <= n_neg;
        r_prod       <= n_prod;
        r_st_level   <= n_st_level;
        r_st_status  <= n_st_status;
        r_res_level  <= n_res_level;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (w_ins) begin
                if (CNT_W'(k) == r_idx) begin
                    r_pos[k] <= r_key;
                    r_lvl[k] <= r_lvl_in;
                end else if (CNT_W'(k) > r_idx && k > 0) begin
                    r_pos[k] <= r_pos[(k + MAX_POINTS - 1) % MAX_POINTS];
                    r_lvl[k] <= r_lvl[(k + MAX_POINTS - 1) % MAX_POINTS];
                end
            end else if (w_rep && CNT_W'(k) == r_idx) begin
                r_lvl[k] <= r_lvl_in;
            end
        end
    end

endmodule

// ----- hdl/piecewise_linear_table_interp.sv -----
// Top level of the piecewise linear table interpolator.
// Items enter through a two-deep command queue and results leave through a
// one-entry result register, so the input side takes up to three more items
// while a result waits to be popped. An accepted item is written into the
// queue, and the back end takes it from the queue head while idle. Clear and
// unused requests go from the take straight to loading the result register; an
// insert searches the table for its position and then loads the result register;
// a query searches the table linearly and then loads the result register, and a
// query between two breakpoints adds a multiply, a divider start and the
// bit-serial divide. The table search and the serial divider set the rate, and
// the back end ends one item before it takes the next. Interpolation truncates
// the quotient toward zero and saturates the sum to the signed level range.
module piecewise_linear_table_interp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_req_type,
    input  logic [plwi_pkg::DATA_WIDTH-1:0] i_point_position,
    input  logic [plwi_pkg::DATA_WIDTH-1:0] i_point_level,
    input  logic [plwi_pkg::DATA_WIDTH-1:0] i_query_position,
    output logic                            empty,
    input  logic                            pop,
    output logic [plwi_pkg::DATA_WIDTH-1:0] o_interp_level,
    output logic [1:0]                      o_status,
    output logic [plwi_pkg::CNT_W-1:0]      o_entry_count
);
    import plwi_pkg::*;

    logic w_cmd_valid, w_cmd_take;
    t_cmd w_cmd;

    plwi_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_point_position (i_point_position),
        .i_point_level    (i_point_level),
        .i_query_position (i_query_position),
        .o_cmd_valid      (w_cmd_valid),
        .o_cmd            (w_cmd),
        .i_cmd_take       (w_cmd_take)
    );

    plwi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_take     (w_cmd_take),
        .empty          (empty),
        .pop            (pop),
        .o_interp_level (o_interp_level),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    a_err_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_interp_level == '0))
        else $error("flagged result carries a nonzero level");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_EMPTY) |-> (o_entry_count == '0))
        else $error("empty-table flag with nonzero entry count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_FULL) |-> (o_entry_count == CNT_W'(MAX_POINTS)))
        else $error("dropped insert without a full table");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_entry_count <= CNT_W'(MAX_POINTS)))
        else $error("entry count beyond table size");

    a_take_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take |-> w_cmd_valid)
        else $error("command taken from an empty queue");

endmodule
